// ----- hdl/apsp_pkg.sv -----
`timescale 1ns / 1ps

package apsp_pkg;

  // Width of a stored distance and of a delivered distance.
  localparam int unsigned DIST_W = 31;
  localparam int unsigned OUT_W  = 30;

  // No path between two vertices.
  localparam logic [OUT_W-1:0] INF_DIST = 30'h3FFF_FFFF;

  // Vertex count register.
  localparam int unsigned VC_W = 7;
  localparam logic [VC_W-1:0] VC_RESET = 7'd64;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_SOLVE = 2'd2,
    REQ_READ  = 2'd3
  } req_type_t;

  // Input word.
  typedef struct packed {
    req_type_t   req_type;
    logic [5:0]  src_vertex;
    logic [5:0]  dst_vertex;
    logic [29:0] edge_weight;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [29:0] distance;
    req_type_t   done_type;
  } out_word_t;

endpackage

// ----- hdl/apsp_ram.sv -----
`timescale 1ns / 1ps

module apsp_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rda_en,
  input  logic [$clog2(DEPTH)-1:0] rda_addr,
  output logic [WIDTH-1:0]         rda_data,
  input  logic                     rdb_en,
  input  logic [$clog2(DEPTH)-1:0] rdb_addr,
  output logic [WIDTH-1:0]         rdb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rda_en) begin
      rda_data <= mem[rda_addr];
    end
    if (rdb_en) begin
      rdb_data <= mem[rdb_addr];
    end
  end

endmodule

// ----- hdl/apsp_relax.sv -----
`timescale 1ns / 1ps

module apsp_relax (
  input  logic [apsp_pkg::DIST_W-1:0] via_ik,
  input  logic [apsp_pkg::DIST_W-1:0] via_kj,
  input  logic [apsp_pkg::DIST_W-1:0] cur_ij,
  output logic [apsp_pkg::DIST_W-1:0] sum,
  output logic                        update
);

  import apsp_pkg::*;

  logic [DIST_W:0] full_sum;

  // Path through the intermediate vertex, kept to the stored width.
  assign full_sum = {1'b0, via_ik} + {1'b0, via_kj};
  assign sum      = full_sum[DIST_W-1:0];

  // Take the detour only when it is strictly shorter.
  assign update = (sum < cur_ij);

endmodule

// ----- hdl/all_pairs_shortest_path_top.sv -----
`timescale 1ns / 1ps

// All-pairs shortest path engine. The distance matrix lives in one RAM with
// one write and two registered read ports; a single add-compare unit does
// every relaxation. After reset the block clears the matrix with in_ready
// low. A solve over n = min(vertex_count, MAX_VERTICES) vertices does one
// relaxation per cycle, pausing at the start of each row to fetch the row's
// entry in column k. One request is worked at a time; the result word waits
// in an output register so the next request can be taken while it is
// pending.
module all_pairs_shortest_path_top #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  apsp_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output apsp_pkg::out_word_t  out_data,
  input  logic                 cfg_wr_en,
  input  logic [6:0]           cfg_wr_data
);

  import apsp_pkg::*;

  localparam int unsigned VW    = $clog2(MAX_VERTICES);
  localparam int unsigned AW    = 2 * VW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned NW    = $clog2(MAX_VERTICES + 1);
  localparam int unsigned XW    = (NW > VC_W) ? NW : VC_W;
  localparam logic [XW-1:0] MAX_X = XW'(MAX_VERTICES);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ROWA,
    S_ROW,
    S_DRAIN,
    S_RDWAIT,
    S_OUT
  } state_t;

  state_t            state_r;
  logic [VC_W-1:0]   vc_r;
  logic [VW-1:0]     k_r;
  logic [VW-1:0]     i_r;
  logic [VW-1:0]     j_r;
  logic [XW-1:0]     n_r;
  logic [DIST_W-1:0] a_r;
  logic              first_r;
  logic              p_vld_r;
  logic [AW-1:0]     p_addr_r;
  logic              clr_reply_r;
  req_type_t         req_r;
  logic [OUT_W-1:0]  res_r;
  logic              out_valid_r;
  out_word_t         out_data_r;

  logic              accept;
  logic [XW-1:0]     n_cur;
  logic [XW-1:0]     src_x;
  logic [XW-1:0]     dst_x;
  logic [VW-1:0]     src_v;
  logic [VW-1:0]     dst_v;
  logic              rd_in_range;
  logic              wr_in_range;
  logic              last_j;
  logic              last_i;
  logic              last_k;
  logic              clr_last_j;
  logic              clr_last_i;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DIST_W-1:0] mem_wdata;
  logic              rda_en;
  logic [AW-1:0]     rda_addr;
  logic [DIST_W-1:0] rda_data;
  logic              rdb_en;
  logic [AW-1:0]     rdb_addr;
  logic [DIST_W-1:0] rdb_data;

  logic              clr_we;
  logic              edge_we;
  logic              relax_we;
  logic [DIST_W-1:0] relax_sum;
  logic              relax_upd;

  // Handshake and active vertex count.
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign n_cur = (XW'(vc_r) > MAX_X) ? MAX_X : XW'(vc_r);
  assign src_x = XW'(in_data.src_vertex);
  assign dst_x = XW'(in_data.dst_vertex);
  assign src_v = VW'(in_data.src_vertex);
  assign dst_v = VW'(in_data.dst_vertex);

  assign rd_in_range = (src_x < n_cur) && (dst_x < n_cur);
  assign wr_in_range = (src_x < MAX_X) && (dst_x < MAX_X);

  // Loop end detection for the solve and the clearing sweep.
  assign last_j     = (XW'(j_r) == n_r - XW'(1));
  assign last_i     = (XW'(i_r) == n_r - XW'(1));
  assign last_k     = (XW'(k_r) == n_r - XW'(1));
  assign clr_last_j = (XW'(j_r) == MAX_X - XW'(1));
  assign clr_last_i = (XW'(i_r) == MAX_X - XW'(1));

  // Shared add-compare unit for the relaxation in flight.
  apsp_relax u_relax (
    .via_ik (a_r),
    .via_kj (rdb_data),
    .cur_ij (rda_data),
    .sum    (relax_sum),
    .update (relax_upd)
  );

  // Write port sources: clearing sweep, edge write, relaxation writeback.
  assign clr_we   = (state_r == S_CLEAR);
  assign edge_we  = accept && (in_data.req_type == REQ_WRITE) && wr_in_range;
  assign relax_we = p_vld_r && relax_upd;

  always_comb begin
    mem_we    = clr_we || edge_we || relax_we;
    mem_waddr = p_addr_r;
    mem_wdata = relax_sum;
    if (clr_we) begin
      mem_waddr = {i_r, j_r};
      mem_wdata = (i_r == j_r) ? '0 : {1'b0, INF_DIST};
    end else if (edge_we) begin
      mem_waddr = {src_v, dst_v};
      mem_wdata = {1'b0, in_data.edge_weight};
    end
  end

  // Read port A fetches the row entry in column k, the current entry or a
  // requested entry; port B fetches the entry of row k.
  always_comb begin
    rda_en   = 1'b0;
    rda_addr = {i_r, j_r};
    rdb_en   = 1'b0;
    rdb_addr = {k_r, j_r};
    case (state_r)
      S_ROWA: begin
        rda_en   = 1'b1;
        rda_addr = {i_r, k_r};
      end
      S_ROW: begin
        rda_en = 1'b1;
        rdb_en = 1'b1;
      end
      S_IDLE: begin
        rda_en   = accept && (in_data.req_type == REQ_READ);
        rda_addr = {src_v, dst_v};
      end
      default: begin
        rda_en = 1'b0;
      end
    endcase
  end

  apsp_ram #(
    .WIDTH (DIST_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk      (clk),
    .wr_en    (mem_we),
    .wr_addr  (mem_waddr),
    .wr_data  (mem_wdata),
    .rda_en   (rda_en),
    .rda_addr (rda_addr),
    .rda_data (rda_data),
    .rdb_en   (rdb_en),
    .rdb_addr (rdb_addr),
    .rdb_data (rdb_data)
  );

  // Sequencer, loop counters and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      vc_r        <= VC_RESET;
      k_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      first_r     <= 1'b0;
      p_vld_r     <= 1'b0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        vc_r <= cfg_wr_data;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      p_vld_r <= 1'b0;
      first_r <= 1'b0;

      case (state_r)
        S_CLEAR: begin
          if (clr_last_j) begin
            j_r <= '0;
            if (clr_last_i) begin
              i_r     <= '0;
              state_r <= clr_reply_r ? S_OUT : S_IDLE;
            end else begin
              i_r <= i_r + VW'(1);
            end
          end else begin
            j_r <= j_r + VW'(1);
          end
        end

        S_IDLE: begin
          if (accept) begin
            req_r <= in_data.req_type;
            res_r <= '0;
            k_r   <= '0;
            i_r   <= '0;
            j_r   <= '0;
            case (in_data.req_type)
              REQ_CLEAR: begin
                clr_reply_r <= 1'b1;
                state_r     <= S_CLEAR;
              end
              REQ_WRITE: begin
                state_r <= S_OUT;
              end
              REQ_SOLVE: begin
                n_r     <= n_cur;
                state_r <= (n_cur == '0) ? S_OUT : S_ROWA;
              end
              REQ_READ: begin
                if (rd_in_range) begin
                  state_r <= S_RDWAIT;
                end else begin
                  res_r   <= INF_DIST;
                  state_r <= S_OUT;
                end
              end
              default: begin
                state_r <= S_OUT;
              end
            endcase
          end
        end

        S_ROWA: begin
          first_r <= 1'b1;
          state_r <= S_ROW;
        end

        S_ROW: begin
          if (first_r) begin
            a_r <= rda_data;
          end
          p_vld_r  <= 1'b1;
          p_addr_r <= {i_r, j_r};
          if (last_j) begin
            j_r <= '0;
            if (last_i) begin
              i_r <= '0;
              if (last_k) begin
                state_r <= S_DRAIN;
              end else begin
                k_r     <= k_r + VW'(1);
                state_r <= S_ROWA;
              end
            end else begin
              i_r     <= i_r + VW'(1);
              state_r <= S_ROWA;
            end
          end else begin
            j_r <= j_r + VW'(1);
          end
        end

        S_DRAIN: begin
          state_r <= S_OUT;
        end

        S_RDWAIT: begin
          res_r   <= (rda_data >= {1'b0, INF_DIST}) ? INF_DIST : rda_data[OUT_W-1:0];
          state_r <= S_OUT;
        end

        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r          <= 1'b1;
            out_data_r.distance  <= res_r;
            out_data_r.done_type <= req_r;
            clr_reply_r          <= 1'b0;
            state_r              <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Only one source drives the RAM write port at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({clr_we, edge_we, relax_we}))
    else $error("RAM write port claimed by more than one source");

  // A relaxation writeback only follows an issued pair of the solve.
  assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r |-> (state_r == S_ROWA || state_r == S_ROW || state_r == S_DRAIN))
    else $error("relaxation writeback outside the solve");

  // Solve counters stay below the active vertex count.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROW) |-> (XW'(k_r) < n_r && XW'(i_r) < n_r && XW'(j_r) < n_r))
    else $error("solve counter beyond active vertex count");

  // A finished request reaches the output register as soon as it is free.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && (!out_valid_r || out_ready)) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result word not loaded into the output register");

endmodule

// ----- verif/apsp_check_pkg.sv -----
`timescale 1ns / 1ps

package apsp_check_pkg;
  import apsp_pkg::*;

  // Matrix size of the block under test and how many errors get printed.
  localparam int unsigned MAX_V = 64;
  localparam int unsigned MAX_SHOWN = 10;

  // Keeps a shadow distance matrix, predicts the reply word of every accepted
  // request and checks the reply words in order of arrival.
  class distance_scoreboard;
    logic [DIST_W-1:0] shadow_dist [MAX_V][MAX_V];
    logic [VC_W-1:0]   vertex_count;
    out_word_t         awaited_replies [$];
    int unsigned       replies_checked;
    int unsigned       error_count;

    function new();
      vertex_count = VC_RESET;
      replies_checked = 0;
      error_count = 0;
      clear_matrix();
    endfunction

    // Zero on the diagonal, no path anywhere else, over the whole matrix.
    function void clear_matrix();
      for (int i = 0; i < MAX_V; i++)
        for (int j = 0; j < MAX_V; j++)
          shadow_dist[i][j] = (i == j) ? '0 : {1'b0, INF_DIST};
    endfunction

    // Counts above the matrix size saturate.
    function int unsigned active_vertices();
      return (vertex_count > MAX_V) ? MAX_V : int'(vertex_count);
    endfunction

    // Relax every pair through every intermediate vertex, k outermost.
    // The sum is kept at 31 bits, as the block keeps it.
    function void relax_all();
      int unsigned       n;
      logic [DIST_W-1:0] to_k;
      logic [DIST_W-1:0] from_k;
      logic [DIST_W-1:0] total;
      n = active_vertices();
      for (int k = 0; k < n; k++) begin
        for (int i = 0; i < n; i++) begin
          to_k = shadow_dist[i][k];
          for (int j = 0; j < n; j++) begin
            from_k = shadow_dist[k][j];
            total = to_k + from_k;
            if (total < shadow_dist[i][j])
              shadow_dist[i][j] = total;
          end
        end
      end
    endfunction

    // Apply one accepted request and queue the reply word it must produce.
    function void predict_reply(in_word_t req);
      out_word_t         reply;
      int unsigned       n;
      logic [DIST_W-1:0] entry;
      reply.distance = '0;
      reply.done_type = req.req_type;
      case (req.req_type)
        REQ_CLEAR: clear_matrix();
        // Six-bit vertex fields always fall inside the matrix, and writes
        // ignore the vertex count.
        REQ_WRITE: shadow_dist[req.src_vertex][req.dst_vertex] = {1'b0, req.edge_weight};
        REQ_SOLVE: relax_all();
        REQ_READ: begin
          n = active_vertices();
          if (req.src_vertex < n && req.dst_vertex < n) begin
            entry = shadow_dist[req.src_vertex][req.dst_vertex];
            reply.distance = (entry >= {1'b0, INF_DIST}) ? INF_DIST : entry[OUT_W-1:0];
          end else begin
            reply.distance = INF_DIST;
          end
        end
        default: ;
      endcase
      awaited_replies.push_back(reply);
    endfunction

    function void flag_error(string detail);
      error_count++;
      if (error_count <= MAX_SHOWN)
        $display("reply %0d: %s", replies_checked, detail);
    endfunction

    // Compare one accepted reply word with the oldest prediction.
    function void check_reply(out_word_t got);
      out_word_t want;
      if (awaited_replies.size() == 0) begin
        flag_error($sformatf("unexpected word, distance %h type %0d",
                             got.distance, got.done_type));
        return;
      end
      want = awaited_replies.pop_front();
      replies_checked++;
      if (got.distance !== want.distance || got.done_type !== want.done_type)
        flag_error($sformatf("expected distance %h type %0d, got distance %h type %0d",
                             want.distance, want.done_type, got.distance, got.done_type));
    endfunction
  endclass

endpackage

// ----- verif/all_pairs_shortest_path_top_test.sv -----
`timescale 1ns / 1ps

module all_pairs_shortest_path_top_test;
  import apsp_pkg::*;
  import apsp_check_pkg::*;

  // The watchdog limit covers a full-size solve, during which no word moves.
  localparam int unsigned WATCHDOG_LIMIT = 1_000_000;
  localparam int unsigned LONG_HOLD_CYCLES = 200;
  localparam int unsigned PHASE_REQUESTS = 10;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  in_word_t        in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_word_t       out_data;
  logic            cfg_wr_en = 1'b0;
  logic [VC_W-1:0] cfg_wr_data = '0;

  bit          gaps_on = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned requests_sent = 0;
  int unsigned idle_cycles = 0;

  distance_scoreboard dist_sb = new();

  all_pairs_shortest_path_top #(
    .MAX_VERTICES(MAX_V)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Watch both channels and feed the scoreboard.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) dist_sb.predict_reply(in_data);
      if (out_valid && out_ready) dist_sb.check_reply(out_data);
    end
  end

  // End the run when no word has moved for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", idle_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin : reply_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      if (out_valid && out_ready) stall_left = pick_gap();
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic in_word_t make_req(req_type_t kind, int unsigned src, int unsigned dst,
                                        logic [29:0] weight);
    in_word_t word;
    word.req_type = kind;
    word.src_vertex = 6'(src);
    word.dst_vertex = 6'(dst);
    word.edge_weight = weight;
    return word;
  endfunction

  // Clear and solve ignore the other fields, so they carry random bits.
  function automatic in_word_t control_req(req_type_t kind);
    return make_req(kind, $urandom_range(0, 63), $urandom_range(0, 63), 30'($urandom));
  endfunction

  // Mostly a vertex inside the active set, sometimes any vertex at all.
  function automatic int unsigned pick_vertex(int unsigned n);
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 63);
    return $urandom_range(0, n - 1);
  endfunction

  function automatic logic [29:0] pick_weight();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return 30'($urandom_range(0, 20));
    if (r == 6) return INF_DIST;
    if (r == 7) return INF_DIST - 30'($urandom_range(1, 3));
    return 30'($urandom);
  endfunction

  function automatic in_word_t random_edge(int unsigned n);
    return make_req(REQ_WRITE, pick_vertex(n), pick_vertex(n), pick_weight());
  endfunction

  function automatic in_word_t random_read(int unsigned n);
    return make_req(REQ_READ, pick_vertex(n), pick_vertex(n), 30'($urandom));
  endfunction

  // Any request with random fields; a solve can be left out where it is too slow.
  function automatic in_word_t random_noise(bit allow_solve);
    req_type_t kind;
    kind = req_type_t'(2'($urandom_range(0, 3)));
    if (kind == REQ_SOLVE && !allow_solve) kind = REQ_READ;
    if (kind == REQ_CLEAR || kind == REQ_SOLVE) return control_req(kind);
    return make_req(kind, $urandom_range(0, 63), $urandom_range(0, 63), 30'($urandom));
  endfunction

  // Offer one word after a random gap and hold it until it is taken.
  // Here valid is only lowered ahead of a gap, so it never drops and rises in one step.
  task automatic send_word(input in_word_t word);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic wait_for_replies();
    in_valid <= 1'b0;
    while (dist_sb.replies_checked != requests_sent) @(posedge clk);
  endtask

  // Only called while the block is idle.
  task automatic write_vertex_count(input logic [VC_W-1:0] count);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    dist_sb.vertex_count = count;
  endtask

  // A small graph: optional clear, some edges, a solve, reads, then sometimes one random request.
  task automatic run_episode(int unsigned n);
    int unsigned edges;
    int unsigned reads;
    if ($urandom_range(0, 3) == 0) send_word(control_req(REQ_CLEAR));
    edges = $urandom_range(1, 2 * n);
    repeat (edges) send_word(random_edge(n));
    send_word(control_req(REQ_SOLVE));
    reads = $urandom_range(2, 6);
    repeat (reads) send_word(random_read(n));
    if ($urandom_range(0, 4) == 0) send_word(random_noise(1'b1));
  endtask

  initial begin : stimulus
    int unsigned phase_start;
    int unsigned n;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset vertex count: diagonal, far corner, near-INF weight, diagonal
    // overwrite, and a clear that restores the diagonal.
    send_word(make_req(REQ_READ, 0, 0, '0));
    send_word(make_req(REQ_READ, 0, 63, '0));
    send_word(make_req(REQ_WRITE, 63, 0, INF_DIST - 30'd1));
    send_word(make_req(REQ_WRITE, 5, 5, 30'd7));
    send_word(make_req(REQ_READ, 5, 5, '0));
    send_word(make_req(REQ_READ, 63, 0, '0));
    send_word(make_req(REQ_CLEAR, 0, 0, '0));
    send_word(make_req(REQ_READ, 5, 5, '0));
    wait_for_replies();

    // No vertices: the solve does nothing and reads miss, but writes land.
    write_vertex_count(7'd0);
    send_word(make_req(REQ_WRITE, 1, 2, 30'd3));
    send_word(make_req(REQ_SOLVE, 0, 0, '0));
    send_word(make_req(REQ_READ, 0, 0, '0));
    wait_for_replies();

    // Four vertices: a chain with a near-INF hop and an INF link back,
    // plus a read just past the active set.
    write_vertex_count(7'd4);
    send_word(make_req(REQ_READ, 1, 2, '0));
    send_word(make_req(REQ_WRITE, 0, 1, 30'd5));
    send_word(make_req(REQ_WRITE, 1, 2, 30'd7));
    send_word(make_req(REQ_WRITE, 2, 3, INF_DIST - 30'd1));
    send_word(make_req(REQ_WRITE, 3, 0, INF_DIST));
    send_word(make_req(REQ_SOLVE, 0, 0, '0));
    send_word(make_req(REQ_READ, 0, 3, '0));
    send_word(make_req(REQ_READ, 0, 2, '0));
    send_word(make_req(REQ_READ, 4, 0, '0));
    wait_for_replies();

    // Count above the matrix size saturates; this is the one full-size solve.
    write_vertex_count(7'd127);
    send_word(make_req(REQ_WRITE, 63, 62, 30'd1));
    send_word(make_req(REQ_WRITE, 62, 0, 30'd2));
    send_word(make_req(REQ_SOLVE, 0, 0, '0));
    send_word(make_req(REQ_READ, 63, 0, '0));
    wait_for_replies();

    // Single vertex.
    write_vertex_count(7'd1);
    send_word(make_req(REQ_SOLVE, 0, 0, '0));
    send_word(make_req(REQ_READ, 0, 0, '0));
    send_word(make_req(REQ_READ, 0, 1, '0));
    wait_for_replies();

    // Random graphs on small vertex counts.
    gaps_on = 1'b1;
    for (int p = 0; p < 4; p++) begin
      n = $urandom_range(2, 8);
      write_vertex_count(7'(n));
      gaps_on = (p != 2);
      if (p == 1) begin
        // Hold the result side off while reads keep coming, so the block
        // fills up and stalls its input.
        gaps_on = 1'b0;
        hold_request = 1'b1;
        repeat (8) send_word(random_read(n));
        gaps_on = 1'b1;
      end
      phase_start = requests_sent;
      while (requests_sent - phase_start < PHASE_REQUESTS) run_episode(n);
      wait_for_replies();
    end

    // Full vertex count with scattered writes, reads and clears.
    write_vertex_count(7'd64);
    repeat (14) send_word(random_noise(1'b0));
    wait_for_replies();

    repeat (50) @(posedge clk);
    if (dist_sb.error_count == 0 && dist_sb.awaited_replies.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d errors, %0d replies missing", dist_sb.error_count,
               dist_sb.awaited_replies.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
